// ----- hdl/spd_pkg.sv -----
// ----------------------------------------------------------------------------
// spd_pkg: shared types and helpers for the serial packet deframer
// Phase and result-kind codes, register indexes, the configuration bundle,
// the result run descriptor and the byte-wide CRC-8 update.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int BEAT_W = 3;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h1D;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BEAT_W-1:0] NAK_LAST_BEAT = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_FLAGS = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_HCRC  = 3'd4,
    PH_DATA  = 3'd5,
    PH_DCRC  = 3'd6
  } phase_t;

  typedef enum logic [KIND_W-1:0] {
    K_PAYLOAD  = 3'd0,
    K_OK       = 3'd1,
    K_SINGLE   = 3'd2,
    K_HDR_CRC  = 3'd3,
    K_TOO_LONG = 3'd4,
    K_DATA_CRC = 3'd5,
    K_NAK      = 3'd6
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SYNC        = 4'd0,
    REG_SINGLE_MASK = 4'd1,
    REG_NAK_MASK    = 4'd2,
    REG_MAX_LEN     = 4'd3,
    REG_RESP_MODE   = 4'd4,
    REG_CODE_HCRC   = 4'd5,
    REG_CODE_LONG   = 4'd6,
    REG_CODE_DCRC   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_byte;
    logic [BYTE_W-1:0] single_mask;
    logic [BYTE_W-1:0] nak_mask;
    logic [BYTE_W-1:0] max_len;
    logic              resp_mode;
    logic [BYTE_W-1:0] code_hcrc;
    logic [BYTE_W-1:0] code_long;
    logic [BYTE_W-1:0] code_dcrc;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sync_byte:   8'h00,
    single_mask: 8'h00,
    nak_mask:    8'h00,
    max_len:     8'hFF,
    resp_mode:   1'b0,
    code_hcrc:   8'h00,
    code_long:   8'h00,
    code_dcrc:   8'h00
  };

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    logic              nak;
    logic [BYTE_W-1:0] code;
  } run_t;

  function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    logic              fb;
    c = crc;
    for (int k = 0; k < BYTE_W; k++) begin
      fb = c[BYTE_W-1] ^ b[BYTE_W-1-k];
      c  = {c[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

endpackage

// ----- hdl/spd_cfg.sv -----
// ----------------------------------------------------------------------------
// spd_cfg: configuration register file
// Write-only registers loaded from the plain write port; unknown indexes drop.
// ----------------------------------------------------------------------------
module spd_cfg import spd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]     cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_SYNC:        cfg_nxt.sync_byte   = cfg_wdata;
        REG_SINGLE_MASK: cfg_nxt.single_mask = cfg_wdata;
        REG_NAK_MASK:    cfg_nxt.nak_mask    = cfg_wdata;
        REG_MAX_LEN:     cfg_nxt.max_len     = cfg_wdata;
        REG_RESP_MODE:   cfg_nxt.resp_mode   = cfg_wdata[0];
        REG_CODE_HCRC:   cfg_nxt.code_hcrc   = cfg_wdata;
        REG_CODE_LONG:   cfg_nxt.code_long   = cfg_wdata;
        REG_CODE_DCRC:   cfg_nxt.code_dcrc   = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hdl/spd_parse.sv -----
// ----------------------------------------------------------------------------
// spd_parse: frame parser
// Track the frame phase, header bytes and running CRC; turn each accepted
// byte into at most one result run descriptor.
// ----------------------------------------------------------------------------
module spd_parse import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              acc,
  input  logic [BYTE_W-1:0] rx_byte,
  output run_t              run
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] flags_r, flags_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [BYTE_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0] crc_upd;
  logic [BYTE_W-1:0] idx_inc;

  assign crc_upd = crc8_update(crc_r, rx_byte);
  assign idx_inc = idx_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    idx_nxt   = idx_r;
    run       = '0;
    run.flags = flags_r;
    run.cmd   = cmd_r;
    run.len   = len_r;
    run.kind  = K_OK;
    run.nak   = !cfg.resp_mode;
    if (acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == cfg.sync_byte) begin
            crc_nxt   = crc8_update(CRC_INIT, rx_byte);
            phase_nxt = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_nxt = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          cmd_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_HCRC;
        end
        PH_HCRC: begin
          phase_nxt = PH_HUNT;
          run.valid = 1'b1;
          priority if (~crc_r != rx_byte) begin
            run.kind = K_HDR_CRC;
            run.code = cfg.code_hcrc;
          end else if ((flags_r & cfg.single_mask) != '0) begin
            run.kind = K_SINGLE;
            run.nak  = 1'b0;
          end else if (len_r > cfg.max_len) begin
            run.kind = K_TOO_LONG;
            run.code = cfg.code_long;
          end else if (len_r == '0) begin
            run.kind = K_OK;
            run.nak  = 1'b0;
          end else begin
            run.valid = 1'b0;
            crc_nxt   = CRC_INIT;
            idx_nxt   = '0;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          run.valid = 1'b1;
          run.kind  = K_PAYLOAD;
          run.data  = rx_byte;
          run.nak   = 1'b0;
          crc_nxt   = crc_upd;
          idx_nxt   = idx_inc;
          if (idx_inc == len_r) phase_nxt = PH_DCRC;
        end
        PH_DCRC: begin
          phase_nxt = PH_HUNT;
          run.valid = 1'b1;
          if (~crc_r == rx_byte) begin
            run.kind = K_OK;
            run.nak  = 1'b0;
          end else begin
            run.kind = K_DATA_CRC;
            run.code = cfg.code_dcrc;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      flags_r <= '0;
      cmd_r   <= '0;
      len_r   <= '0;
      crc_r   <= CRC_INIT;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- hdl/spd_emit.sv -----
// ----------------------------------------------------------------------------
// spd_emit: result sequencer
// Hold one result run and play it out: the status beat, then, when the run
// asks for a NAK, the NAK frame bytes with their CRC built up beat by beat.
// ----------------------------------------------------------------------------
module spd_emit import spd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  run_t              run,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,   // data_byte, frame_flags, frame_command, length_or_value
  output logic [KIND_W-1:0] out_tuser,   // kind
  output logic              out_tlast
);

  logic              valid_r;
  run_t              run_r;
  logic [BEAT_W-1:0] beat_r;
  logic [BYTE_W-1:0] crc_r;
  logic [BYTE_W-1:0] nak_byte;
  logic [BYTE_W-1:0] data_byte;
  logic              last_beat;
  logic              take;

  always_comb begin
    unique case (beat_r)
      3'd1:    nak_byte = cfg.sync_byte;
      3'd2:    nak_byte = cfg.nak_mask | cfg.single_mask;
      3'd3:    nak_byte = run_r.cmd;
      3'd4:    nak_byte = run_r.code;
      3'd5:    nak_byte = ~crc_r;
      default: nak_byte = '0;
    endcase
  end

  assign data_byte = (beat_r == '0) ? run_r.data : nak_byte;
  assign last_beat = (beat_r == '0) ? !run_r.nak : (beat_r == NAK_LAST_BEAT);
  assign take      = valid_r && out_tready;
  assign free      = !valid_r || (out_tready && last_beat);

  assign out_tvalid = valid_r;
  assign out_tuser  = (beat_r == '0) ? run_r.kind : K_NAK;
  assign out_tdata  = {run_r.len, run_r.cmd, run_r.flags, data_byte};
  assign out_tlast  = last_beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= '0;
      crc_r   <= CRC_INIT;
    end else if (run.valid) begin
      valid_r <= 1'b1;
      beat_r  <= '0;
      crc_r   <= CRC_INIT;
    end else if (take) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        beat_r <= beat_r + 3'd1;
        if (beat_r != '0) crc_r <= crc8_update(crc_r, nak_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (run.valid) run_r <= run;
  end

endmodule

// ----- hdl/serial_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// serial_packet_deframer: framed serial receiver with CRC-8 checks
// Latency: a result beat is presented the cycle after the byte that causes it.
// Throughput: one byte per cycle while the output takes each beat; a byte causing
// a status plus NAK frame holds the input until the last NAK beat, the next byte
// going in with that beat, set by the single result sequencer.
// Reset: synchronous, active low; hunting for sync, registers at defaults.
// ----------------------------------------------------------------------------
module serial_packet_deframer import spd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,    // rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,   // data_byte, frame_flags, frame_command, length_or_value
  output logic [KIND_W-1:0]     out_tuser,   // kind
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTE_W-1:0]     cfg_wdata
);

  cfg_t cfg;
  run_t run;
  logic free;
  logic acc;

  assign in_tready = free;
  assign acc       = in_tvalid && free;

  spd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .acc     (acc),
    .rx_byte (in_tdata),
    .run     (run)
  );

  spd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .run        (run),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- dv/serial_packet_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// serial_packet_deframer_tb: self-checking bench for the serial packet deframer
// Drives received bytes over the input stream and checks every result beat
// against a behavioural deframer kept in step with the accepted bytes. A short
// directed plan covers framing corner cases and error reports; random frames
// with random register settings and random stalls on both sides follow.
// ----------------------------------------------------------------------------
module serial_packet_deframer_tb;
  import spd_pkg::*;

  localparam int RANDOM_ITEMS = 380;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_ADDR_W-1:0] REG_NONE = '0;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLE_FIRST = 4'd8;
  localparam logic [CFG_ADDR_W-1:0] REG_HOLE_LAST = 4'd15;

  typedef struct {
    kind_t       kind;
    logic [7:0]  data;
    logic [7:0]  flags;
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic        last;
  } beat_t;

  typedef enum logic [1:0] {
    OP_RX,
    OP_CRC,
    OP_WRITE
  } plan_op_t;

  typedef struct packed {
    plan_op_t               op;
    logic [CFG_ADDR_W-1:0]  idx;
    logic [7:0]             val;
    logic                   typed;
    kind_t                  kind;
    logic [7:0]             data;
  } plan_row_t;

  localparam int PLAN_LEN = 39;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{OP_RX,    REG_NONE,        8'h55, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hFF, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hFF, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_CRC,   REG_NONE,        8'h00, 1'b1, K_OK,       8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hFF, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_CRC,   REG_NONE,        8'h01, 1'b1, K_HDR_CRC,  8'h00},
    '{OP_WRITE, REG_SYNC,        8'hA5, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_SINGLE_MASK, 8'h80, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_NAK_MASK,    8'h40, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_MAX_LEN,     8'h04, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_RESP_MODE,   8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_CODE_HCRC,   8'h11, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_CODE_LONG,   8'h22, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_CODE_DCRC,   8'h33, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_HOLE_LAST,   8'hAA, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hA5, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h80, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h7E, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hFF, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_CRC,   REG_NONE,        8'h00, 1'b1, K_SINGLE,   8'h00},
    '{OP_RX,    REG_NONE,        8'hA5, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h01, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h04, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_WRITE, REG_MAX_LEN,     8'h03, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_CRC,   REG_NONE,        8'h00, 1'b1, K_TOO_LONG, 8'h00},
    '{OP_WRITE, REG_RESP_MODE,   8'hFF, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hA5, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h02, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'h01, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_CRC,   REG_NONE,        8'h00, 1'b0, K_PAYLOAD,  8'h00},
    '{OP_RX,    REG_NONE,        8'hFF, 1'b1, K_PAYLOAD,  8'hFF},
    '{OP_CRC,   REG_NONE,        8'h80, 1'b1, K_DATA_CRC, 8'h00}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;    // rx_byte
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;   // data_byte, frame_flags, frame_command, length_or_value
  logic [KIND_W-1:0]     out_tuser;   // kind
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [BYTE_W-1:0]     cfg_wdata;

  serial_packet_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // deframer shadow state and register copy
  cfg_t        shadow_cfg;
  phase_t      sd_phase;
  logic [7:0]  sd_flags;
  logic [7:0]  sd_cmd;
  logic [7:0]  sd_len;
  logic [7:0]  sd_crc;
  logic [7:0]  sd_idx;

  beat_t       pending_beats[$];
  beat_t       step_beats[$];
  int          rx_items;
  int          rx_beats;
  int          big_frames_left;
  bit          calm;
  int          faults;
  int          cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic logic [7:0] crc8_j1850(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    return c;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_beat(input kind_t k, input logic [7:0] d);
    beat_t bt;
    bt.kind  = k;
    bt.data  = d;
    bt.flags = sd_flags;
    bt.cmd   = sd_cmd;
    bt.len   = sd_len;
    bt.last  = 1'b0;
    step_beats.push_back(bt);
  endtask

  task automatic report_fault(input kind_t k, input logic [7:0] code);
    logic [7:0] nak [5];
    logic [7:0] c;
    add_beat(k, 8'h00);
    if (!shadow_cfg.resp_mode) begin
      nak[0] = shadow_cfg.sync_byte;
      nak[1] = shadow_cfg.nak_mask | shadow_cfg.single_mask;
      nak[2] = sd_cmd;
      nak[3] = code;
      c = CRC_INIT;
      for (int i = 0; i < 4; i++) c = crc8_j1850(c, nak[i]);
      nak[4] = ~c;
      for (int i = 0; i < 5; i++) add_beat(K_NAK, nak[i]);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic typed, input kind_t tk,
                              input logic [7:0] td);
    logic [7:0] check;
    step_beats.delete();
    check = ~sd_crc;
    if (!(sd_phase == PH_HUNT && b != shadow_cfg.sync_byte)) rx_items++;
    case (sd_phase)
      PH_HUNT: begin
        if (b == shadow_cfg.sync_byte) begin
          sd_crc   = crc8_j1850(CRC_INIT, b);
          sd_phase = PH_FLAGS;
        end
      end
      PH_FLAGS: begin
        sd_flags = b;
        sd_crc   = crc8_j1850(sd_crc, b);
        sd_phase = PH_CMD;
      end
      PH_CMD: begin
        sd_cmd   = b;
        sd_crc   = crc8_j1850(sd_crc, b);
        sd_phase = PH_LEN;
      end
      PH_LEN: begin
        sd_len   = b;
        sd_crc   = crc8_j1850(sd_crc, b);
        sd_phase = PH_HCRC;
      end
      PH_HCRC: begin
        sd_phase = PH_HUNT;
        if (check != b) begin
          report_fault(K_HDR_CRC, shadow_cfg.code_hcrc);
        end else if ((sd_flags & shadow_cfg.single_mask) != 8'h00) begin
          add_beat(K_SINGLE, 8'h00);
        end else if (sd_len > shadow_cfg.max_len) begin
          report_fault(K_TOO_LONG, shadow_cfg.code_long);
        end else if (sd_len == 8'h00) begin
          add_beat(K_OK, 8'h00);
        end else begin
          sd_crc   = CRC_INIT;
          sd_idx   = 8'h00;
          sd_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        add_beat(K_PAYLOAD, b);
        sd_crc = crc8_j1850(sd_crc, b);
        sd_idx = sd_idx + 8'd1;
        if (sd_idx == sd_len) sd_phase = PH_DCRC;
      end
      PH_DCRC: begin
        sd_phase = PH_HUNT;
        if (check == b) add_beat(K_OK, 8'h00);
        else report_fault(K_DATA_CRC, shadow_cfg.code_dcrc);
      end
      default: sd_phase = PH_HUNT;
    endcase
    if (step_beats.size() > 0) begin
      if (typed) begin
        step_beats[0].kind = tk;
        step_beats[0].data = td;
      end
      step_beats[step_beats.size() - 1].last = 1'b1;
      foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    end
  endtask

  task automatic send_rx(input logic [7:0] b, input logic typed, input kind_t tk,
                         input logic [7:0] td);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    deframe_byte(b, typed, tk, td);
    rx_beats++;
    if (rx_beats % 50 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_rx(b, 1'b0, K_PAYLOAD, 8'h00);
  endtask

  // drain all results before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SYNC:        shadow_cfg.sync_byte   = val;
      REG_SINGLE_MASK: shadow_cfg.single_mask = val;
      REG_NAK_MASK:    shadow_cfg.nak_mask    = val;
      REG_MAX_LEN:     shadow_cfg.max_len     = val;
      REG_RESP_MODE:   shadow_cfg.resp_mode   = val[0];
      REG_CODE_HCRC:   shadow_cfg.code_hcrc   = val;
      REG_CODE_LONG:   shadow_cfg.code_long   = val;
      REG_CODE_DCRC:   shadow_cfg.code_dcrc   = val;
      default: ;
    endcase
  endtask

  task automatic random_settings();
    logic [7:0] m;
    settle();
    write_reg(REG_SYNC, pick_byte());
    case ($urandom_range(0, 2))
      0: m = 8'h00;
      1: m = 8'h01 << $urandom_range(0, 7);
      default: m = pick_byte();
    endcase
    write_reg(REG_SINGLE_MASK, m);
    write_reg(REG_NAK_MASK, pick_byte());
    case ($urandom_range(0, 3))
      0: m = 8'hFF;
      1: m = 8'h00;
      2: m = 8'($urandom_range(1, 8));
      default: m = 8'($urandom);
    endcase
    write_reg(REG_MAX_LEN, m);
    write_reg(REG_RESP_MODE, 8'($urandom));
    write_reg(REG_CODE_HCRC, pick_byte());
    write_reg(REG_CODE_LONG, pick_byte());
    write_reg(REG_CODE_DCRC, pick_byte());
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_ADDR_W'($urandom_range(REG_HOLE_FIRST, REG_HOLE_LAST)), 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    logic [7:0] b;
    logic [7:0] flip;
    int         r;
    // finish off any broken frame with line noise
    while (sd_phase != PH_HUNT) send_plain(8'($urandom));
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == shadow_cfg.sync_byte) b = ~b;
        send_plain(b);
      end
      return;
    end
    send_plain(shadow_cfg.sync_byte);
    b = 8'($urandom);
    if (shadow_cfg.single_mask != 8'h00 && $urandom_range(0, 2) != 0)
      b = b & ~shadow_cfg.single_mask;
    send_plain(b);
    send_plain(8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 4 && big_frames_left > 0 && shadow_cfg.max_len == 8'hFF) begin
      b = 8'hFF;
      big_frames_left--;
    end else if (r < 14) begin
      b = 8'($urandom);
      if (b > 8'd40 && shadow_cfg.max_len >= b) b = b & 8'h0F;
    end else begin
      b = 8'($urandom_range(0, 6));
    end
    send_plain(b);
    if ($urandom_range(0, 19) == 0) return;
    flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    send_plain(~sd_crc ^ flip);
    while (sd_phase == PH_DATA) send_plain(8'($urandom));
    if (sd_phase == PH_DCRC) begin
      flip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      send_plain(~sd_crc ^ flip);
    end
  endtask

  initial begin
    plan_row_t  row;
    logic [7:0] b;
    bit         writing;
    int         stop_at;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    calm       = 1'b0;
    writing    = 1'b0;
    rx_items   = 0;
    rx_beats   = 0;
    big_frames_left = 1;
    shadow_cfg = '0;
    shadow_cfg.max_len = 8'hFF;
    sd_phase   = PH_HUNT;
    sd_flags   = 8'h00;
    sd_cmd     = 8'h00;
    sd_len     = 8'h00;
    sd_crc     = CRC_INIT;
    sd_idx     = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_LEN; i++) begin
      row = PLAN[i];
      if (row.op == OP_WRITE) begin
        if (!writing) begin
          settle();
          writing = 1'b1;
        end
        write_reg(row.idx, row.val);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        b = (row.op == OP_CRC) ? (~sd_crc ^ row.val) : row.val;
        send_rx(b, row.typed, row.kind, row.data);
      end
    end
    if (writing) cfg_we <= 1'b0;

    stop_at = rx_items + RANDOM_ITEMS;
    while (rx_items < stop_at) begin
      if (rx_beats % 60 < 6) random_settings();
      random_frame();
    end

    settle();
    if (faults == 0) begin
      $display("serial_packet_deframer_tb: clean");
    end else begin
      $display("serial_packet_deframer_tb: errors");
    end
    $finish;
  end

  initial begin
    int w;
    while (!rst_n) @(posedge clk);
    forever begin
      w = calm ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: kind %0d data %02h", out_tuser, out_tdata[7:0]);
        faults++;
      end else begin
        e = pending_beats.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_tuser);
          faults++;
        end
        if (out_tdata[7:0] !== e.data) begin
          $error("data_byte: expected %02h actual %02h", e.data, out_tdata[7:0]);
          faults++;
        end
        if (out_tdata[15:8] !== e.flags) begin
          $error("frame_flags: expected %02h actual %02h", e.flags, out_tdata[15:8]);
          faults++;
        end
        if (out_tdata[23:16] !== e.cmd) begin
          $error("frame_command: expected %02h actual %02h", e.cmd, out_tdata[23:16]);
          faults++;
        end
        if (out_tdata[31:24] !== e.len) begin
          $error("length_or_value: expected %02h actual %02h", e.len, out_tdata[31:24]);
          faults++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0b actual %0b", e.last, out_tlast);
          faults++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("serial_packet_deframer_tb: errors");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
hdl/spd_pkg.sv
hdl/spd_cfg.sv
hdl/spd_parse.sv
hdl/spd_emit.sv
hdl/serial_packet_deframer.sv
dv/serial_packet_deframer_tb.sv
